FILE: src/topk_min_heap_unit_macros.svh
// Assertion helpers for the heap datapath.
`ifndef TOPK_MIN_HEAP_UNIT_MACROS_SVH
`define TOPK_MIN_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TMH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TMH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tmh_pkg.sv
package tmh_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 31;
  localparam int SCORE_W     = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Word index of the capacity register on the config port.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REPLACED  = 2'd1,
    ST_DISCARDED = 2'd2
  } push_status_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_EVAL,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_RD,
    OP_DN_CMP
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic discard;
    logic pop_more;
    logic pos_zero;
    logic up_swap;
    logic dn_swap;
  } dp_stat_t;

endpackage

FILE: src/tmh_if.sv
interface tmh_in_if;
  import tmh_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [ID_W-1:0]           item_id;
  logic signed [SCORE_W-1:0] item_score;

  modport source (output valid, cmd, item_id, item_score, input ready);
  modport sink   (input valid, cmd, item_id, item_score, output ready);
endinterface

interface tmh_out_if;
  import tmh_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      out_valid;
  logic [ID_W-1:0]           out_id;
  logic signed [SCORE_W-1:0] out_score;
  logic [1:0]                push_status;
  logic [CNT_W-1:0]          stored_count;

  modport source (output valid, out_valid, out_id, out_score, push_status, stored_count,
                  input ready);
  modport sink   (input valid, out_valid, out_id, out_score, push_status, stored_count,
                  output ready);
endinterface

FILE: src/tmh_ctrl.sv
module tmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              res_free,
  output logic              res_load,
  input  tmh_pkg::dp_stat_t stat,
  output tmh_pkg::dp_cmd_t  cmd
);
  import tmh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (!stat.is_pop && !stat.full) state_next = S_UP_RD;
        else if (stat.is_pop && stat.empty) state_next = S_DONE;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_pop) state_next = stat.pop_more ? S_DN_RD : S_DONE;
        else state_next = stat.discard ? S_DONE : S_DN_RD;
      end
      S_UP_RD: begin
        state_next = stat.pos_zero ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_next = stat.up_swap ? S_UP_RD : S_DONE;
      end
      S_DN_RD: begin
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        state_next = stat.dn_swap ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        if (res_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_load = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_NONE;
      end
      S_FETCH:  cmd.op = OP_FETCH;
      S_EVAL:   cmd.op = OP_EVAL;
      S_UP_RD:  cmd.op = OP_UP_RD;
      S_UP_CMP: cmd.op = OP_UP_CMP;
      S_DN_RD:  cmd.op = OP_DN_RD;
      S_DN_CMP: cmd.op = OP_DN_CMP;
      S_DONE:   res_load = res_free;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: src/tmh_dpath.sv
`include "topk_min_heap_unit_macros.svh"

module tmh_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  tmh_pkg::dp_cmd_t                   cmd,
  output tmh_pkg::dp_stat_t                  stat,
  input  logic                               in_cmd,
  input  logic [tmh_pkg::ID_W-1:0]           in_id,
  input  logic signed [tmh_pkg::SCORE_W-1:0] in_score,
  input  logic [tmh_pkg::CNT_W-1:0]          cap_eff,
  output logic                               res_valid,
  output logic [tmh_pkg::ID_W-1:0]           res_id,
  output logic signed [tmh_pkg::SCORE_W-1:0] res_score,
  output logic [1:0]                         res_status,
  output logic [tmh_pkg::CNT_W-1:0]          res_count
);
  import tmh_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_a, rd_b;

  logic               item_cmd;
  entry_t             item;
  entry_t             x_entry;
  logic [ADDR_W-1:0]  pos;
  logic [CNT_W-1:0]   count;
  push_status_t       status;

  logic [ADDR_W-1:0]  parent;
  logic [ADDR_W:0]    left;
  logic [ADDR_W+1:0]  right;
  logic               l_ok, r_ok, lt_l, lt_r;
  logic signed [SCORE_W-1:0] best_score;
  entry_t             best_entry;
  logic [ADDR_W-1:0]  best_addr;

  logic               mem_we;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  entry_t             wdata;
  logic               item_is_pop, full;

  assign item_is_pop = (item_cmd == CMD_POP);
  assign full        = (count >= cap_eff);

  // Heap index arithmetic
  assign parent = (pos - 1'b1) >> 1;
  assign left   = {pos, 1'b1};
  assign right  = {1'b0, left} + 1'b1;

  // Child selection: strict less, left child wins ties
  assign l_ok       = left < count;
  assign r_ok       = right < {1'b0, count};
  assign lt_l       = l_ok && (rd_a.score < x_entry.score);
  assign best_score = lt_l ? rd_a.score : x_entry.score;
  assign lt_r       = r_ok && (rd_b.score < best_score);
  assign best_entry = lt_r ? rd_b : rd_a;
  assign best_addr  = lt_r ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

  assign stat.is_pop   = item_is_pop;
  assign stat.full     = full;
  assign stat.empty    = (count == '0);
  assign stat.discard  = (item.score <= rd_a.score);
  assign stat.pop_more = (count != CNT_W'(1));
  assign stat.pos_zero = (pos == '0);
  assign stat.up_swap  = (rd_a.score > x_entry.score);
  assign stat.dn_swap  = lt_l || lt_r;

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    case (cmd.op)
      OP_FETCH: raddr_b = count[ADDR_W-1:0] - 1'b1;
      OP_UP_RD: raddr_a = parent;
      OP_DN_RD: begin
        raddr_a = left[ADDR_W-1:0];
        raddr_b = right[ADDR_W-1:0];
      end
      default: raddr_a = '0;
    endcase
  end

  // Hole-based sifting: the moving entry stays in x_entry until it lands
  always_comb begin
    mem_we = 1'b0;
    waddr  = pos;
    wdata  = x_entry;
    case (cmd.op)
      OP_UP_RD: mem_we = stat.pos_zero;
      OP_UP_CMP: begin
        mem_we = 1'b1;
        wdata  = stat.up_swap ? rd_a : x_entry;
      end
      OP_DN_CMP: begin
        mem_we = 1'b1;
        wdata  = stat.dn_swap ? best_entry : x_entry;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        OP_FETCH: if (!item_is_pop && !full) count <= count + 1'b1;
        OP_EVAL:  if (item_is_pop) count <= count - 1'b1;
        default:  count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        item_cmd   <= in_cmd;
        item.id    <= in_id;
        item.score <= in_score;
      end
      OP_FETCH: begin
        res_valid <= 1'b0;
        res_id    <= '0;
        res_score <= '0;
        status    <= ST_INSERTED;
        pos       <= count[ADDR_W-1:0];
        x_entry   <= item;
      end
      OP_EVAL: begin
        pos <= '0;
        if (item_is_pop) begin
          res_valid <= 1'b1;
          res_id    <= rd_a.id;
          res_score <= rd_a.score;
          x_entry   <= rd_b;
        end else begin
          status  <= stat.discard ? ST_DISCARDED : ST_REPLACED;
          x_entry <= item;
        end
      end
      OP_UP_CMP: if (stat.up_swap) pos <= parent;
      OP_DN_CMP: if (stat.dn_swap) pos <= best_addr;
      default: pos <= pos;
    endcase
  end

  assign res_status = status;
  assign res_count  = count;

  `TMH_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_ENTRIES), "count overflow")
  `TMH_ASSERT_IMP(a_up_in_heap, clk, rst, cmd.op == OP_UP_RD, {1'b0, pos} < count, "sift-up out of range")
  `TMH_ASSERT_IMP(a_dn_in_heap, clk, rst, cmd.op == OP_DN_RD, {1'b0, pos} < count, "sift-down out of range")
  `TMH_ASSERT_NXT(a_ins_count, clk, rst, cmd.op == OP_FETCH && !item_is_pop && !full, count == $past(count) + 1'b1, "insert did not grow heap")

endmodule

FILE: src/topk_min_heap_unit.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   cmd, item_id, item_score
// out_ch    out  valid/ready   out_valid, out_id, out_score, push_status, stored_count
// config    in   APB write     capacity_limit at byte address 0
//
// One item at a time: the next item is taken only after the last result has been loaded
// into the output register. An insert sifts up at most six levels; a replace or pop sifts
// down at most six levels, each level a child read through the store's two read ports,
// then a compare and write back.
// Reset clears the entry count and sets capacity_limit to 64; the store is not cleared.
// A finished result waits in the output register; hold the engine in its final state
// only while that register is still occupied and not drained.
module topk_min_heap_unit (
  input  logic                             clk,
  input  logic                             rst,
  tmh_in_if.sink                           in_ch,
  tmh_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tmh_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [tmh_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tmh_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import tmh_pkg::*;

  logic [CNT_W-1:0] cap_reg;
  logic [CNT_W-1:0] cap_eff;
  logic             cfg_wr;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic                      res_free, res_load;
  logic                      res_valid;
  logic [ID_W-1:0]           res_id;
  logic signed [SCORE_W-1:0] res_score;
  logic [1:0]                res_status;
  logic [CNT_W-1:0]          res_count;

  logic                      out_full;
  logic                      o_valid;
  logic [ID_W-1:0]           o_id;
  logic signed [SCORE_W-1:0] o_score;
  logic [1:0]                o_status;
  logic [CNT_W-1:0]          o_count;

  // Config port: single capacity register, zero-wait
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_reg <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DATA_W-CNT_W){1'b0}}, cap_reg} : '0;

  // Zero acts as one slot; anything above the store depth saturates
  always_comb begin
    if (cap_reg == '0) cap_eff = CNT_W'(1);
    else if (cap_reg > CNT_W'(MAX_ENTRIES)) cap_eff = CNT_W'(MAX_ENTRIES);
    else cap_eff = cap_reg;
  end

  tmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .res_free (res_free),
    .res_load (res_load),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  tmh_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .in_cmd     (in_ch.cmd),
    .in_id      (in_ch.item_id),
    .in_score   (in_ch.item_score),
    .cap_eff    (cap_eff),
    .res_valid  (res_valid),
    .res_id     (res_id),
    .res_score  (res_score),
    .res_status (res_status),
    .res_count  (res_count)
  );

  // Output register: free when empty or being drained this cycle
  assign res_free = !out_full || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_load) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      o_valid  <= res_valid;
      o_id     <= res_id;
      o_score  <= res_score;
      o_status <= res_status;
      o_count  <= res_count;
    end
  end

  assign out_ch.valid        = out_full;
  assign out_ch.out_valid    = o_valid;
  assign out_ch.out_id       = o_id;
  assign out_ch.out_score    = o_score;
  assign out_ch.push_status  = o_status;
  assign out_ch.stored_count = o_count;

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tmh_pkg::*;

  // Cycles to let pass once the last result is in, before a register write or
  // the end of the run, so that a sift over all six levels can finish.
  localparam int SETTLE_CYCLES = 24;
  // Receiver hold-off used to back the heap up into its input.
  localparam int HOLD_OFF_CYCLES = 300;

  // One result as the heap reports it.
  typedef struct packed {
    logic                      hit;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    push_status_t              status;
    logic [CNT_W-1:0]          count;
  } heap_result_t;

  typedef enum {ROW_ITEM, ROW_CAPACITY} row_kind_t;

  // Directed stimulus: an item, or a capacity write taken while idle.
  typedef struct {
    row_kind_t                 kind;
    logic                      cmd;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    int unsigned               cap;
    bit                        known;
    heap_result_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tmh_in_if  in_ch ();
  tmh_out_if out_ch ();

  topk_min_heap_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap: entries, occupancy and the capacity register as last written.
  entry_t           shadow_heap [MAX_ENTRIES];
  int               shadow_count;
  logic [CNT_W-1:0] shadow_cap;

  heap_result_t expected_results [$];
  stim_row_t    directed_rows [$];

  int mismatch_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_request;
  int items_sent;
  int phases_run;
  int status_tally [3];
  int pops_hit;
  int pops_empty;
  int peak_count;

  // Sift the root entry down: only a strictly smaller child swaps, and the
  // left child wins a tie between the two children.
  function automatic void settle_root();
    int     pos;
    int     best;
    int     left_i;
    int     right_i;
    entry_t held;
    pos = 0;
    while (pos < shadow_count) begin
      best    = pos;
      left_i  = 2 * pos + 1;
      right_i = 2 * pos + 2;
      if (left_i < shadow_count &&
          $signed(shadow_heap[left_i].score) < $signed(shadow_heap[best].score)) begin
        best = left_i;
      end
      if (right_i < shadow_count &&
          $signed(shadow_heap[right_i].score) < $signed(shadow_heap[best].score)) begin
        best = right_i;
      end
      if (best == pos) break;
      held              = shadow_heap[pos];
      shadow_heap[pos]  = shadow_heap[best];
      shadow_heap[best] = held;
      pos               = best;
    end
  endfunction

  // Apply one command to the shadow heap and return the result it causes.
  function automatic heap_result_t apply_heap_op(input logic cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic signed [SCORE_W-1:0] score);
    heap_result_t res;
    int           room;
    int           slot;
    int           parent;
    entry_t       held;
    res        = '0;
    res.status = ST_INSERTED;
    // Zero capacity acts as one slot; anything above the store saturates.
    if (shadow_cap == 0) begin
      room = 1;
    end else if (shadow_cap > MAX_ENTRIES) begin
      room = MAX_ENTRIES;
    end else begin
      room = shadow_cap;
    end
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= room) begin
        // Full, or capacity lowered under the occupancy: replace or discard.
        if (shadow_count == 0 || score <= $signed(shadow_heap[0].score)) begin
          res.status = ST_DISCARDED;
        end else begin
          shadow_heap[0].id    = id;
          shadow_heap[0].score = score;
          settle_root();
          res.status = ST_REPLACED;
        end
      end else begin
        slot                    = shadow_count;
        shadow_heap[slot].id    = id;
        shadow_heap[slot].score = score;
        while (slot > 0) begin
          parent = (slot - 1) / 2;
          if ($signed(shadow_heap[parent].score) <= $signed(shadow_heap[slot].score)) break;
          held                = shadow_heap[parent];
          shadow_heap[parent] = shadow_heap[slot];
          shadow_heap[slot]   = held;
          slot                = parent;
        end
        shadow_count++;
      end
    end else if (shadow_count > 0) begin
      res.hit   = 1'b1;
      res.id    = shadow_heap[0].id;
      res.score = shadow_heap[0].score;
      shadow_count--;
      if (shadow_count > 0) begin
        shadow_heap[0] = shadow_heap[shadow_count];
        settle_root();
      end
    end
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t ns: %s", $time, what);
  endtask

  task automatic add_item(input logic cmd, input logic [ID_W-1:0] id,
                          input logic signed [SCORE_W-1:0] score);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.cmd   = cmd;
    row.id    = id;
    row.score = score;
    row.cap   = 0;
    row.known = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input logic cmd, input logic [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] score, input logic hit,
                           input logic [ID_W-1:0] out_id,
                           input logic signed [SCORE_W-1:0] out_score,
                           input push_status_t status, input int count);
    stim_row_t row;
    row.kind        = ROW_ITEM;
    row.cmd         = cmd;
    row.id          = id;
    row.score       = score;
    row.cap         = 0;
    row.known       = 1'b1;
    row.want        = '0;
    row.want.hit    = hit;
    row.want.id     = out_id;
    row.want.score  = out_score;
    row.want.status = status;
    row.want.count  = CNT_W'(count);
    directed_rows.push_back(row);
  endtask

  task automatic add_cap(input int unsigned value);
    stim_row_t row;
    row.kind  = ROW_CAPACITY;
    row.cmd   = CMD_PUSH;
    row.id    = '0;
    row.score = '0;
    row.cap   = value;
    row.known = 1'b0;
    row.want  = '0;
    directed_rows.push_back(row);
  endtask

  // Offer one item, optionally after random idle cycles. Enter and leave at a
  // falling edge; valid stays high on return so back-to-back items need no gap.
  task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                           input logic signed [SCORE_W-1:0] score,
                           input bit known, input heap_result_t typed);
    heap_result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.item_id    <= id;
    in_ch.item_score <= score;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Item accepted at this edge: predict its result and queue it.
    predicted = apply_heap_op(cmd, id, score);
    expected_results.push_back(known ? typed : predicted);
    items_sent++;
    if (cmd == CMD_POP) begin
      if (predicted.hit) pops_hit++;
      else pops_empty++;
    end else begin
      status_tally[int'(predicted.status)]++;
    end
    if (shadow_count > peak_count) peak_count = shadow_count;
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the engine settle.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup, then access until pready.
  task automatic write_capacity(input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * REG_CAPACITY);
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_cap = CNT_W'(value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random phase: settle, set capacity, idling and stalling, then stream items.
  task automatic run_phase(input int unsigned cap, input int push_pct, input int idle_pct,
                           input int stall_pct, input int n_items, input bit squeeze);
    logic                      cmd;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
    int                        small_score;
    drain_and_settle();
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    phases_run++;
    write_capacity(cap);
    if (squeeze) begin
      // Hand the receiver a long hold-off; set it off the falling edge so the
      // receiver picks it up cleanly.
      @(posedge clk);
      hold_request = HOLD_OFF_CYCLES;
      @(negedge clk);
    end
    repeat (n_items) begin
      cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      id  = ID_W'($urandom);
      case ($urandom_range(7))
        0, 1, 2: begin
          // Narrow band around zero: plenty of equal scores.
          small_score = $urandom_range(16);
          score       = small_score - 8;
        end
        3: begin
          case ($urandom_range(3))
            0:       score = 32'sh7FFF_FFFF;
            1:       score = 32'sh8000_0000;
            2:       score = 32'sh0000_0000;
            default: score = 32'shFFFF_FFFF;
          endcase
        end
        default: score = SCORE_W'($urandom);
      endcase
      send_item(cmd, id, score, 1'b0, '0);
    end
  endtask

  // Receiver: stall at random, or hold off for a requested stretch of cycles.
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result arrived with no item outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_valid !== want.hit)
          flag_mismatch($sformatf("out_valid %b, want %b", out_ch.out_valid, want.hit));
        if (out_ch.out_id !== want.id)
          flag_mismatch($sformatf("out_id %h, want %h", out_ch.out_id, want.id));
        if (out_ch.out_score !== want.score)
          flag_mismatch($sformatf("out_score %h, want %h", out_ch.out_score, want.score));
        if (out_ch.push_status !== want.status)
          flag_mismatch($sformatf("push_status %0d, want %s", out_ch.push_status,
                                  want.status.name()));
        if (out_ch.stored_count !== want.count)
          flag_mismatch($sformatf("stored_count %0d, want %0d", out_ch.stored_count,
                                  want.count));
      end
    end
  end

  initial begin
    // Drive every input to a known value and hold reset.
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_PUSH;
    in_ch.item_id    = '0;
    in_ch.item_score = '0;
    out_ch.ready     = 1'b0;
    mismatch_count   = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    hold_request     = 0;
    items_sent       = 0;
    phases_run       = 0;
    status_tally     = '{0, 0, 0};
    pops_hit         = 0;
    pops_empty       = 0;
    peak_count       = 0;
    shadow_count     = 0;
    shadow_cap       = CAP_RESET;
    foreach (shadow_heap[i]) shadow_heap[i] = '0;

    // Directed part. Typed results are the obvious ones; the rest go through
    // the shadow heap.
    add_known(CMD_POP,  31'h1234_5678, 32'sh0000_0000, 1'b0, '0, '0, ST_INSERTED, 0);
    add_known(CMD_PUSH, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0, '0, ST_INSERTED, 1);
    add_known(CMD_PUSH, 31'h0000_0000, 32'sh8000_0000, 1'b0, '0, '0, ST_INSERTED, 2);
    add_item(CMD_PUSH, 31'h2AAA_AAAA, 32'sh0000_0000);
    add_item(CMD_PUSH, 31'h5555_5555, 32'shFFFF_FFFF);
    add_item(CMD_PUSH, 31'h0000_0003, 32'shFFFF_FFFF);
    // Lower capacity under the occupancy: the heap now counts as full.
    add_cap(2);
    add_known(CMD_PUSH, 31'h0000_0009, 32'sh8000_0000, 1'b0, '0, '0, ST_DISCARDED, 5);
    add_item(CMD_PUSH, 31'h0000_000A, 32'sh0001_0000);
    add_item(CMD_PUSH, 31'h0000_000B, 32'shFFFF_FFFF);
    repeat (5) add_item(CMD_POP, 31'h0, 32'sh0);
    add_known(CMD_POP,  31'h7FFF_FFFF, 32'shFFFF_FFFF, 1'b0, '0, '0, ST_INSERTED, 0);
    // Zero capacity behaves as a single slot.
    add_cap(0);
    add_known(CMD_PUSH, 31'h0000_0001, 32'sh0000_0064, 1'b0, '0, '0, ST_INSERTED, 1);
    add_known(CMD_PUSH, 31'h0000_0002, 32'sh0000_0032, 1'b0, '0, '0, ST_DISCARDED, 1);
    add_known(CMD_PUSH, 31'h0000_0003, 32'sh0000_00C8, 1'b0, '0, '0, ST_REPLACED, 1);
    // Capacity above the store saturates.
    add_cap(127);
    add_known(CMD_POP,  31'h0000_0000, 32'sh0000_0000, 1'b1, 31'h0000_0003,
              32'sh0000_00C8, ST_INSERTED, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAPACITY) begin
        drain_and_settle();
        write_capacity(directed_rows[i].cap);
      end else begin
        send_item(directed_rows[i].cmd, directed_rows[i].id, directed_rows[i].score,
                  directed_rows[i].known, directed_rows[i].want);
      end
    end

    // Random part: fill to full, churn at full, shrink, single slot,
    // saturated capacity, and a drain under backpressure.
    run_phase(64,  75, 0,  0,  300, 1'b0);
    run_phase(64,  50, 70, 0,  300, 1'b0);
    run_phase(9,   60, 0,  70, 300, 1'b0);
    run_phase(0,   50, 31, 31, 200, 1'b0);
    run_phase(127, 65, 31, 31, 300, 1'b0);
    run_phase(40,  30, 0,  0,  400, 1'b1);

    drain_and_settle();
    $display("Ran %0d items over %0d random phases: %0d inserted, %0d replaced, %0d discarded",
             items_sent, phases_run, status_tally[0], status_tally[1], status_tally[2]);
    $display("Pops: %0d returned an entry, %0d on an empty heap; peak occupancy %0d",
             pops_hit, pops_empty, peak_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Watchdog expired with %0d results outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/tmh_pkg.sv
src/tmh_if.sv
src/tmh_ctrl.sv
src/tmh_dpath.sv
src/topk_min_heap_unit.sv
dv/testbench.sv
